@@ src/utf8_stream_decoder_core_macros.svh @@
// Assertion macros for the UTF-8 stream decoder RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define U8D_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define U8D_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define U8D_ASSERT(label, clk, rst, prop, msg)
`define U8D_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

@@ src/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; used by the front, queue, back and top modules.
`default_nettype none
package utf8d_pkg;

  localparam int CpW = 21;
  localparam logic [CpW-1:0] RepCp = 21'h00FFFD;

  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0]     pre;
    logic           main_vld;
    logic [CpW-1:0] cp;
    logic           rep;
    logic [1:0]     post;
  } job_t;

endpackage
`default_nettype wire

@@ src/utf8d_front.sv @@
// Front end: accepts bytes, tracks the pending sequence, builds result jobs.
// Depends on utf8d_pkg.
`default_nettype none
module utf8d_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tlast,
  input  wire logic          q_full,
  output logic               push,
  output utf8d_pkg::job_t    job
);
  import utf8d_pkg::*;

  logic [1:0]     needed;
  logic [1:0]     held;
  logic [CpW-1:0] partial;
  logic [1:0]     needed_next;
  logic [1:0]     held_next;
  logic [CpW-1:0] partial_next;

  logic           pending;
  logic           is_cont;
  logic [2:0]     held_inc;
  logic [CpW-1:0] merged;
  logic           accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign pending  = needed != 2'd0;
  assign is_cont  = s_tdata[7:6] == 2'b10;
  assign held_inc = {1'b0, held} + 3'd1;
  assign merged   = {partial[CpW-7:0], s_tdata[5:0]};

  always_comb begin
    needed_next  = needed;
    held_next    = held;
    partial_next = partial;
    job          = '0;
    if (pending && is_cont) begin
      if (held_inc >= {1'b0, needed}) begin
        job.main_vld = 1'b1;
        job.cp       = merged;
        needed_next  = 2'd0;
        held_next    = 2'd0;
        partial_next = '0;
      end else begin
        partial_next = merged;
        held_next    = held_inc[1:0];
      end
    end else begin
      if (pending) begin
        job.pre = held_inc[1:0];
      end
      needed_next  = 2'd0;
      held_next    = 2'd0;
      partial_next = '0;
      if (!s_tdata[7]) begin
        job.main_vld = 1'b1;
        job.cp       = {{(CpW-8){1'b0}}, s_tdata};
      end else if (s_tdata[7:5] == 3'b110) begin
        needed_next  = 2'd1;
        partial_next = {{(CpW-5){1'b0}}, s_tdata[4:0]};
      end else if (s_tdata[7:4] == 4'b1110) begin
        needed_next  = 2'd2;
        partial_next = {{(CpW-4){1'b0}}, s_tdata[3:0]};
      end else if (s_tdata[7:3] == 5'b11110) begin
        needed_next  = 2'd3;
        partial_next = {{(CpW-3){1'b0}}, s_tdata[2:0]};
      end else begin
        job.main_vld = 1'b1;
        job.cp       = RepCp;
        job.rep      = 1'b1;
      end
    end
    if (s_tlast && needed_next != 2'd0) begin
      job.post     = held_next + 2'd1;
      needed_next  = 2'd0;
      held_next    = 2'd0;
      partial_next = '0;
    end
  end

  assign push = accept && (job.pre != 2'd0 || job.main_vld || job.post != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      needed  <= 2'd0;
      held    <= 2'd0;
      partial <= '0;
    end else if (accept) begin
      needed  <= needed_next;
      held    <= held_next;
      partial <= partial_next;
    end
  end

endmodule
`default_nettype wire

@@ src/utf8d_queue.sv @@
// Small job queue between the front and back ends.
// Depends on utf8d_pkg.
`default_nettype none
module utf8d_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire utf8d_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output utf8d_pkg::job_t    head
);
  import utf8d_pkg::*;

  job_t             slots [QDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QCntW-1:0] count;

  assign full     = count == QCntW'(QDepth);
  assign nonempty = count != '0;
  assign head     = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/utf8d_back.sv @@
// Back end: expands one job into its result items and drives the output register.
// Depends on utf8d_pkg and utf8_stream_decoder_core_macros.svh.
`default_nettype none
`include "utf8_stream_decoder_core_macros.svh"
module utf8d_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_nonempty,
  input  wire utf8d_pkg::job_t q_head,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [23:0]        m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);
  import utf8d_pkg::*;

  job_t           cur;
  logic           cur_valid;
  job_t           cur_next;
  logic           out_valid;
  logic [CpW-1:0] out_cp;
  logic           out_rep;
  logic           out_last;

  logic           adv;
  logic           fire;
  logic [CpW-1:0] gen_cp;
  logic           gen_rep;
  logic           gen_last;

  assign adv  = !out_valid || m_tready;
  assign fire = adv && cur_valid;
  assign pop  = q_nonempty && (!cur_valid || (fire && gen_last));

  always_comb begin
    cur_next = cur;
    gen_cp   = RepCp;
    gen_rep  = 1'b1;
    if (cur.pre != 2'd0) begin
      cur_next.pre = cur.pre - 2'd1;
      gen_last = cur_next.pre == 2'd0 && !cur.main_vld && cur.post == 2'd0;
    end else if (cur.main_vld) begin
      cur_next.main_vld = 1'b0;
      gen_cp   = cur.cp;
      gen_rep  = cur.rep;
      gen_last = cur.post == 2'd0;
    end else begin
      cur_next.post = cur.post - 2'd1;
      gen_last = cur_next.post == 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (fire && gen_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end else if (fire) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_cp   <= gen_cp;
      out_rep  <= gen_rep;
      out_last <= gen_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(24-CpW){1'b0}}, out_cp};
  assign m_tuser  = out_rep;
  assign m_tlast  = out_last;

  `U8D_ASSERT(a_job_not_empty, clk, rst,
    cur_valid |-> (cur.pre != 2'd0 || cur.main_vld || cur.post != 2'd0),
    "active job has no results left")
  `U8D_ASSERT(a_job_continues, clk, rst,
    (fire && !gen_last) |=> cur_valid,
    "job dropped before its last result")
  `U8D_ASSERT(a_rep_value, clk, rst,
    (out_valid && out_rep) |-> out_cp == RepCp,
    "replacement result without U+FFFD")
  `U8D_ASSERT_NEVER(a_pop_while_busy, clk, rst,
    pop && cur_valid && !(fire && gen_last),
    "job loaded over an unfinished one")

endmodule
`default_nettype wire

@@ src/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder: one text byte per cycle in, decoded code points out; s_tready
// is low while the job queue is full. Each accepted byte's job passes the queue, the
// result sequencer and the output register. Throughput: one byte per cycle while bytes
// give at most one result each and m_tready holds; a 4-job queue absorbs bursts.
// Reset (rst, synchronous): clears the pending sequence, the queue and the output stage.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back.
`default_nettype none
module utf8_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tlast,   // final_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
  output logic             m_tuser,   // [0] replaced
  output logic             m_tlast    // job_end (last result of each byte)
);
  import utf8d_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_nonempty;
  job_t q_in;
  job_t q_head;

  utf8d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (q_push),
    .job      (q_in)
  );

  utf8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  utf8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire
